/* hdl/svc_pkg.sv */
// Shared types and constants for the sphere voxel coverage block.
`default_nettype none

package svc_pkg;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_HIT,
    ST_MASK,
    ST_EMIT
  } state_t;

  // Register indexes on the configuration port (word address bits)
  localparam logic [1:0] REG_ELEMENT  = 2'd0;
  localparam logic [1:0] REG_OVERRIDE = 2'd1;
  localparam logic [1:0] REG_OVR_EN   = 2'd2;

  // Half of the reach factor, Q0.20
  localparam logic [19:0] K_HALF_Q20 = 20'd845148;

  // Smallest usable voxel edge (1.0 in Q8.8)
  localparam logic [15:0] MIN_EDGE = 16'd256;

  // Neighbour offsets per axis (-1, 0, +1) and cube size
  localparam int SPAN  = 3;
  localparam int CUBE  = SPAN * SPAN * SPAN;

  // Step index of the last quotient bit of the home-voxel divider
  localparam logic [4:0] DIV_LAST = 5'd16;

endpackage

`default_nettype wire

/* hdl/sphere_voxel_coverage.sv */
// Sphere voxel coverage: home voxel divider, neighbour test and voxel emitter.
// Sequence: request accepted, prep state, then per axis the divide steps and a test state,
//   a mask state, then the first voxel enters the output register.
// Throughput: one covered voxel per cycle after that while the output is not stalled
//   (1 to 27 per request); a live request stalls the input until its last voxel is emitted.
// The shared restoring divider, one quotient bit per cycle, sets the per-request time.
// Reset (rst, synchronous) returns to idle, empties the output and reloads register defaults.
`default_nettype none

module sphere_voxel_coverage (
  input  logic                clk,
  input  logic                rst,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  // request channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                particle_exists,
  input  logic signed [23:0]  pos_x,
  input  logic signed [23:0]  pos_y,
  input  logic signed [23:0]  pos_z,
  input  logic [15:0]         radius,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [16:0]  vox_x,
  output logic signed [16:0]  vox_y,
  output logic signed [16:0]  vox_z,
  output logic                last_of_run,
  output logic                reach_clamped
);

  // Configuration registers
  logic [15:0] element_voxel_size;
  logic [15:0] override_voxel_size;
  logic        override_enable;

  // Sequencer
  svc_pkg::state_t state, state_next;

  // Request data
  logic signed [23:0] pos [3];
  logic [15:0]        vsize;
  logic [35:0]        reach_num;
  logic [37:0]        lim;
  logic               clamped;

  // Divider
  logic [1:0]  axis;
  logic [4:0]  step;
  logic [17:0] rem;
  logic [24:0] numsh;
  logic [16:0] quo;
  logic        neg;

  // Per-axis results
  logic [2:0]         hit  [3];
  logic signed [17:0] home [3];
  logic [26:0]        mask;

  logic cfg_wr;
  logic in_fire;
  logic emit_go;

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      element_voxel_size  <= 16'd256;
      override_voxel_size <= 16'd256;
      override_enable     <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        svc_pkg::REG_ELEMENT:  element_voxel_size  <= pwdata[15:0];
        svc_pkg::REG_OVERRIDE: override_voxel_size <= pwdata[15:0];
        svc_pkg::REG_OVR_EN:   override_enable     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      svc_pkg::REG_ELEMENT:  prdata = {16'd0, element_voxel_size};
      svc_pkg::REG_OVERRIDE: prdata = {16'd0, override_voxel_size};
      svc_pkg::REG_OVR_EN:   prdata = {31'd0, override_enable};
      default:               prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------------------
  assign in_stall = (state != svc_pkg::ST_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign emit_go  = (state == svc_pkg::ST_EMIT) && (!out_valid || !out_stall);

  // ---------------------------------------------------------------------------
  // Divider load: numerator 2|p| + s, first 8 bits go straight to the remainder
  // ---------------------------------------------------------------------------
  logic [1:0]         ld_axis;
  logic signed [23:0] ld_pos;
  logic [23:0]        ld_abs;
  logic [24:0]        ld_num;
  logic [16:0]        dvsr;

  always_comb begin
    ld_axis = (state == svc_pkg::ST_PREP) ? 2'd0 : axis + 2'd1;
    ld_pos  = pos[ld_axis];
    ld_abs  = ld_pos[23] ? 24'(-ld_pos) : 24'(ld_pos);
    ld_num  = {ld_abs, 1'b0} + {9'd0, vsize};
    dvsr    = {vsize, 1'b0};
  end

  // One restoring step
  logic [17:0] div_t;
  logic        div_ge;

  always_comb begin
    div_t  = {rem[16:0], numsh[24]};
    div_ge = (div_t >= {1'b0, dvsr});
  end

  // ---------------------------------------------------------------------------
  // Axis test: offset of the centre from the home voxel, then three neighbours
  // ---------------------------------------------------------------------------
  logic signed [18:0] off2;
  logic signed [18:0] off;
  logic signed [18:0] off_sgn;
  logic signed [19:0] nbr_diff [3];
  logic [19:0]        dist_abs [3];
  logic [2:0]         hit_now;
  logic signed [17:0] home_now;

  always_comb begin
    // rem - s is even: twice the offset of |p| from q*s
    off2    = $signed({1'b0, rem}) - $signed({3'b000, vsize});
    off     = off2 >>> 1;
    off_sgn = neg ? -off : off;
    nbr_diff[0] = 20'(off_sgn) + $signed({4'd0, vsize});
    nbr_diff[1] = 20'(off_sgn);
    nbr_diff[2] = 20'(off_sgn) - $signed({4'd0, vsize});
    for (int d = 0; d < svc_pkg::SPAN; d++) begin
      dist_abs[d] = nbr_diff[d][19] ? 20'(-nbr_diff[d]) : 20'(nbr_diff[d]);
      hit_now[d]  = ({dist_abs[d], 20'd0} <= {2'b00, lim});
    end
    home_now = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  end

  // ---------------------------------------------------------------------------
  // Emitter: lowest remaining candidate in x, y, z order
  // ---------------------------------------------------------------------------
  logic [26:0] sel_bit;
  logic [1:0]  sel_ix, sel_iy, sel_iz;
  logic        sel_last;

  always_comb begin
    sel_bit = '0;
    sel_ix  = 2'd0;
    sel_iy  = 2'd0;
    sel_iz  = 2'd0;
    for (int ix = svc_pkg::SPAN - 1; ix >= 0; ix--) begin
      for (int iy = svc_pkg::SPAN - 1; iy >= 0; iy--) begin
        for (int iz = svc_pkg::SPAN - 1; iz >= 0; iz--) begin
          if (mask[ix * 9 + iy * 3 + iz]) begin
            sel_bit = 27'(1) << (ix * 9 + iy * 3 + iz);
            sel_ix  = 2'(ix);
            sel_iy  = 2'(iy);
            sel_iz  = 2'(iz);
          end
        end
      end
    end
    sel_last = ((mask & ~sel_bit) == 27'd0);
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= svc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      svc_pkg::ST_IDLE: begin
        if (in_fire && particle_exists) begin
          state_next = svc_pkg::ST_PREP;
        end
      end
      svc_pkg::ST_PREP: state_next = svc_pkg::ST_DIV;
      svc_pkg::ST_DIV: begin
        if (step == svc_pkg::DIV_LAST) begin
          state_next = svc_pkg::ST_HIT;
        end
      end
      svc_pkg::ST_HIT: begin
        if (axis == 2'd2) begin
          state_next = svc_pkg::ST_MASK;
        end else begin
          state_next = svc_pkg::ST_DIV;
        end
      end
      svc_pkg::ST_MASK: state_next = svc_pkg::ST_EMIT;
      svc_pkg::ST_EMIT: begin
        if (emit_go && sel_last) begin
          state_next = svc_pkg::ST_IDLE;
        end
      end
      default: state_next = svc_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    // capture the request, pick the edge and form the reach numerator
    if (in_fire) begin
      pos[0]    <= pos_x;
      pos[1]    <= pos_y;
      pos[2]    <= pos_z;
      reach_num <= 36'(radius) * 36'(svc_pkg::K_HALF_Q20);
      if (override_enable) begin
        vsize <= (override_voxel_size < svc_pkg::MIN_EDGE) ? svc_pkg::MIN_EDGE
                                                            : override_voxel_size;
      end else begin
        vsize <= (element_voxel_size < svc_pkg::MIN_EDGE) ? svc_pkg::MIN_EDGE
                                                           : element_voxel_size;
      end
    end

    // threshold, clamp flag and first divider load
    if (state == svc_pkg::ST_PREP) begin
      lim     <= {2'b00, reach_num} + {3'b000, vsize, 19'd0};
      clamped <= (reach_num >= {vsize, 20'd0});
    end

    // load the divider for the next axis
    if (state == svc_pkg::ST_PREP ||
        (state == svc_pkg::ST_HIT && axis != 2'd2)) begin
      axis  <= ld_axis;
      step  <= 5'd0;
      rem   <= {10'd0, ld_num[24:17]};
      numsh <= {ld_num[16:0], 8'd0};
      quo   <= 17'd0;
      neg   <= ld_pos[23];
    end

    // advance one quotient bit
    if (state == svc_pkg::ST_DIV) begin
      rem   <= div_ge ? div_t - {1'b0, dvsr} : div_t;
      quo   <= {quo[15:0], div_ge};
      numsh <= {numsh[23:0], 1'b0};
      step  <= step + 5'd1;
    end

    // store the home index and neighbour hits of this axis
    if (state == svc_pkg::ST_HIT) begin
      hit[axis]  <= hit_now;
      home[axis] <= home_now;
    end

    // combine the axes into the candidate cube
    if (state == svc_pkg::ST_MASK) begin
      for (int ix = 0; ix < svc_pkg::SPAN; ix++) begin
        for (int iy = 0; iy < svc_pkg::SPAN; iy++) begin
          for (int iz = 0; iz < svc_pkg::SPAN; iz++) begin
            mask[ix * 9 + iy * 3 + iz] <= hit[0][ix] & hit[1][iy] & hit[2][iz];
          end
        end
      end
    end else if (emit_go) begin
      mask <= mask & ~sel_bit;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic signed [17:0] cand_x, cand_y, cand_z;

  always_comb begin
    cand_x = home[0] + $signed({16'd0, sel_ix}) - 18'sd1;
    cand_y = home[1] + $signed({16'd0, sel_iy}) - 18'sd1;
    cand_z = home[2] + $signed({16'd0, sel_iz}) - 18'sd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_go) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      vox_x         <= cand_x[16:0];
      vox_y         <= cand_y[16:0];
      vox_z         <= cand_z[16:0];
      last_of_run   <= sel_last;
      reach_clamped <= clamped;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_live_starts: assert property (@(posedge clk) disable iff (rst)
    in_fire && particle_exists |=> state == svc_pkg::ST_PREP)
    else $error("live request did not start the sequencer");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    state == svc_pkg::ST_DIV |-> rem < {1'b0, dvsr})
    else $error("divider remainder not below divisor");

  a_home_hits: assert property (@(posedge clk) disable iff (rst)
    state == svc_pkg::ST_MASK |-> hit[0][1] && hit[1][1] && hit[2][1])
    else $error("home voxel failed the coverage test");

  a_mask_live: assert property (@(posedge clk) disable iff (rst)
    state == svc_pkg::ST_EMIT |-> mask != 27'd0)
    else $error("emitter running with no candidates left");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    emit_go && sel_last |=> state == svc_pkg::ST_IDLE && out_valid && last_of_run)
    else $error("last voxel did not close the request");

endmodule

`default_nettype wire

/* verif/sphere_voxel_coverage_tb.sv */
// Self-checking testbench for the sphere voxel coverage block.
`timescale 1ns / 1ps

module sphere_voxel_coverage_tb;

  localparam int MAX_REACH    = 1;
  localparam int DRAIN_CYCLES = 100;
  localparam int HOLD_CYCLES  = 600;
  localparam int PHASE_LIVE   = 43;
  localparam int MAX_PRINTS   = 40;

  typedef struct {
    logic              exists;
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
    logic [15:0]        radius;
  } particle_t;

  typedef struct {
    logic [16:0] vx;
    logic [16:0] vy;
    logic [16:0] vz;
    logic        last_flag;
    logic        clamp_flag;
  } voxel_t;

  typedef enum logic [1:0] {RX_FLOW, RX_LIGHT, RX_HEAVY, RX_PULSE} rx_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [3:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  logic               in_valid        = 1'b0;
  logic               in_stall;
  logic               particle_exists = 1'b0;
  logic signed [23:0] pos_x           = '0;
  logic signed [23:0] pos_y           = '0;
  logic signed [23:0] pos_z           = '0;
  logic [15:0]        radius          = '0;

  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [16:0] vox_x;
  logic signed [16:0] vox_y;
  logic signed [16:0] vox_z;
  logic               last_of_run;
  logic               reach_clamped;

  // register copies kept in step with every write
  logic [15:0] cfg_element = 16'd256;
  logic [15:0] cfg_override = 16'd256;
  logic        cfg_ovr_en = 1'b0;

  particle_t particle_queue[$];
  voxel_t    voxel_expect[$];
  particle_t req_cur;

  int burst_left = 0;
  int gap_left   = 0;
  int hold_left  = 0;
  logic hold_arm   = 1'b0;
  logic hold_spent = 1'b0;
  rx_mode_t rx_mode = RX_FLOW;
  int mode_left = 0;
  logic stall_pick;
  voxel_t got_exp;

  int fail_count    = 0;
  int requests_sent = 0;
  int live_sent     = 0;
  int voxels_seen   = 0;
  int clamped_seen  = 0;
  int setting_count = 0;

  sphere_voxel_coverage u_top (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .particle_exists(particle_exists), .pos_x(pos_x), .pos_y(pos_y),
    .pos_z(pos_z), .radius(radius),
    .out_valid(out_valid), .out_stall(out_stall),
    .vox_x(vox_x), .vox_y(vox_y), .vox_z(vox_z),
    .last_of_run(last_of_run), .reach_clamped(reach_clamped)
  );

  always #4 clk = ~clk;

  task automatic report_mismatch(input string msg);
    if (fail_count < MAX_PRINTS) $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [16:0] got,
                             input logic [16:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // Voxel edge in use, with the minimum edge applied
  function automatic longint voxel_edge();
    longint e;
    e = cfg_ovr_en ? cfg_override : cfg_element;
    if (e < svc_pkg::MIN_EDGE) e = svc_pkg::MIN_EDGE;
    return e;
  endfunction

  // Work out the covered voxels of one accepted particle request
  task automatic predict_coverage(input particle_t p);
    longint pc[3];
    longint home[3];
    longint cand[3];
    longint off[3];
    longint edge_len, ap, diff, reach_num, reach, lim;
    logic clamped, hit;
    voxel_t found[$];
    voxel_t v;
    int dx, dy, dz, a;
    if (!p.exists) return;
    pc[0] = p.x;
    pc[1] = p.y;
    pc[2] = p.z;
    edge_len = voxel_edge();
    // home voxel: round half away from zero
    for (a = 0; a < 3; a++) begin
      ap = (pc[a] < 0) ? -pc[a] : pc[a];
      home[a] = (2 * ap + edge_len) / (2 * edge_len);
      if (pc[a] < 0) home[a] = -home[a];
    end
    reach_num = longint'(p.radius) * longint'(svc_pkg::K_HALF_Q20);
    reach = reach_num / (edge_len <<< 20) + 1;
    clamped = (reach > MAX_REACH);
    if (clamped) reach = MAX_REACH;
    lim = reach_num + (edge_len <<< 19);
    // scan x outer, then y, then z
    for (dx = -reach; dx <= reach; dx++) begin
      for (dy = -reach; dy <= reach; dy++) begin
        for (dz = -reach; dz <= reach; dz++) begin
          off[0] = dx;
          off[1] = dy;
          off[2] = dz;
          hit = 1'b1;
          for (a = 0; a < 3; a++) begin
            cand[a] = home[a] + off[a];
            diff = pc[a] - cand[a] * edge_len;
            if (diff < 0) diff = -diff;
            if ((diff <<< 20) > lim) hit = 1'b0;
          end
          if (hit) begin
            v.vx = cand[0][16:0];
            v.vy = cand[1][16:0];
            v.vz = cand[2][16:0];
            v.last_flag = 1'b0;
            v.clamp_flag = clamped;
            found.push_back(v);
          end
        end
      end
    end
    if (found.size() != 0) found[found.size() - 1].last_flag = 1'b1;
    foreach (found[i]) voxel_expect.push_back(found[i]);
    live_sent++;
  endtask

  // Request driver: bursts of requests with random gaps between them
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_coverage(req_cur);
        requests_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (particle_queue.size() != 0) begin
          req_cur = particle_queue.pop_front();
          particle_exists <= req_cur.exists;
          pos_x <= req_cur.x;
          pos_y <= req_cur.y;
          pos_z <= req_cur.z;
          radius <= req_cur.radius;
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, armed once by the stimulus
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_spent <= 1'b0;
    end else if (hold_arm && !hold_spent) begin
      hold_left <= HOLD_CYCLES;
      hold_spent <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result monitor: stall pattern and field-by-field compare
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      rx_mode <= RX_FLOW;
      mode_left <= 0;
    end else begin
      if (mode_left == 0) begin
        rx_mode <= rx_mode_t'($urandom_range(0, 3));
        mode_left <= $urandom_range(16, 96);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (rx_mode)
        RX_FLOW:  stall_pick = 1'b0;
        RX_LIGHT: stall_pick = ($urandom_range(0, 3) == 0);
        RX_HEAVY: stall_pick = ($urandom_range(0, 3) != 0);
        default:  stall_pick = mode_left[2];
      endcase
      out_stall <= (hold_left != 0) || stall_pick;
      if (out_valid && !out_stall) begin
        if (voxel_expect.size() == 0) begin
          report_mismatch($sformatf("voxel %0d,%0d,%0d with nothing expected",
                                    vox_x, vox_y, vox_z));
        end else begin
          got_exp = voxel_expect.pop_front();
          check_field("vox_x", vox_x, got_exp.vx);
          check_field("vox_y", vox_y, got_exp.vy);
          check_field("vox_z", vox_z, got_exp.vz);
          check_field("last_of_run", {16'd0, last_of_run}, {16'd0, got_exp.last_flag});
          check_field("reach_clamped", {16'd0, reach_clamped}, {16'd0, got_exp.clamp_flag});
          voxels_seen++;
          if (reach_clamped) clamped_seen++;
        end
      end
    end
  end

  // One register write: setup phase, then access phase until pready
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      svc_pkg::REG_ELEMENT:  cfg_element = val[15:0];
      svc_pkg::REG_OVERRIDE: cfg_override = val[15:0];
      svc_pkg::REG_OVR_EN:   cfg_ovr_en = val[0];
      default: ;
    endcase
  endtask

  task automatic push_particle(input logic e, input logic signed [23:0] x,
                               input logic signed [23:0] y, input logic signed [23:0] z,
                               input logic [15:0] r);
    particle_t p;
    p.exists = e;
    p.x = x;
    p.y = y;
    p.z = z;
    p.radius = r;
    particle_queue.push_back(p);
  endtask

  // Wait for all requests and voxels, then let a request with no result drain
  task automatic wait_idle();
    @(negedge clk);
    while (particle_queue.size() != 0 || in_valid || voxel_expect.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Random coordinate: full range, near a rounding boundary, near origin or near the ends
  function automatic logic signed [23:0] rand_coord(input longint edge_len);
    longint v;
    case ($urandom_range(0, 3))
      0: v = $urandom;
      1: v = longint'($urandom_range(0, 60)) * edge_len + edge_len / 2
             + longint'($urandom_range(0, 4)) - 2;
      2: v = longint'($urandom_range(0, 3 * edge_len));
      default: v = 64'sd8388607 - longint'($urandom_range(0, edge_len));
    endcase
    if ($urandom_range(0, 1) == 1) v = -v;
    return v[23:0];
  endfunction

  // Fill the request queue with random particles for the current voxel edge
  task automatic run_random_phase(input logic arm_hold);
    particle_t p;
    longint edge_len;
    int live;
    int cap;
    edge_len = voxel_edge();
    cap = (2 * edge_len > 65535) ? 65535 : 2 * edge_len;
    live = 0;
    setting_count++;
    while (live < PHASE_LIVE) begin
      p.exists = ($urandom_range(0, 7) != 0);
      p.x = rand_coord(edge_len);
      p.y = rand_coord(edge_len);
      p.z = rand_coord(edge_len);
      case ($urandom_range(0, 5))
        0:       p.radius = 16'd0;
        1, 2:    p.radius = $urandom;
        default: p.radius = $urandom_range(0, cap);
      endcase
      if (p.exists) live++;
      particle_queue.push_back(p);
    end
    if (arm_hold) begin
      @(posedge clk);
      hold_arm <= 1'b1;
    end
    wait_idle();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // directed requests at reset settings (edge 1.0)
    push_particle(1'b0, 24'sd0, 24'sd0, 24'sd0, 16'd0);
    push_particle(1'b1, 24'sd0, 24'sd0, 24'sd0, 16'd0);
    push_particle(1'b1, 24'sd128, 24'sd128, 24'sd128, 16'd0);
    push_particle(1'b1, -24'sd128, -24'sd128, -24'sd128, 16'd0);
    push_particle(1'b1, 24'sd127, -24'sd127, 24'sd129, 16'd0);
    push_particle(1'b1, 24'sd8388607, 24'sd8388607, 24'sd8388607, 16'd0);
    push_particle(1'b1, -24'sd8388608, -24'sd8388608, -24'sd8388608, 16'd65535);
    push_particle(1'b1, 24'sd8388607, -24'sd8388608, 24'sd0, 16'd65535);
    push_particle(1'b1, 24'sd0, 24'sd0, 24'sd0, 16'd317);
    push_particle(1'b1, 24'sd0, 24'sd0, 24'sd0, 16'd318);
    push_particle(1'b1, 24'sd0, 24'sd0, 24'sd0, 16'd65535);
    push_particle(1'b0, -24'sd8388608, 24'sd8388607, 24'sd0, 16'd65535);
    push_particle(1'b1, 24'sd200, -24'sd300, 24'sd50, 16'd100);
    push_particle(1'b1, 24'h555555, 24'h2AAAAA, 24'hAAAAAA, 16'hAAAA);
    push_particle(1'b1, 24'hAAAAAA, 24'h555555, 24'h2AAAAA, 16'h5555);
    push_particle(1'b1, 24'sd64, -24'sd192, 24'sd320, 16'd159);
    wait_idle();

    // random phases over several voxel edge settings
    write_reg(svc_pkg::REG_ELEMENT, 32'd256);
    write_reg(svc_pkg::REG_OVR_EN, 32'd0);
    run_random_phase(1'b1);

    write_reg(svc_pkg::REG_ELEMENT, 32'd65535);
    run_random_phase(1'b0);

    write_reg(svc_pkg::REG_OVERRIDE, $urandom_range(0, 255));
    write_reg(svc_pkg::REG_OVR_EN, 32'd1);
    run_random_phase(1'b0);

    write_reg(svc_pkg::REG_OVERRIDE, 32'd65535);
    run_random_phase(1'b0);

    write_reg(svc_pkg::REG_ELEMENT, $urandom_range(256, 65535));
    write_reg(svc_pkg::REG_OVERRIDE, $urandom_range(256, 65535));
    run_random_phase(1'b0);

    write_reg(svc_pkg::REG_OVR_EN, 32'd0);
    run_random_phase(1'b0);

    if (voxel_expect.size() != 0)
      report_mismatch($sformatf("%0d voxels never arrived", voxel_expect.size()));
    $display("run: %0d particle requests (%0d live) over %0d edge settings",
             requests_sent, live_sent, setting_count);
    $display("run: %0d voxels compared, %0d with reach clamped, %0d mismatches",
             voxels_seen, clamped_seen, fail_count);
    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // Watchdog on the whole run
  initial begin
    #6000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
